// ===== rtl/gershgorin_eigen_bound_defines.svh =====
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound: assertion macros
// Shared concurrent assertion forms. Every form samples on clock and is
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GERSHGORIN_EIGEN_BOUND_DEFINES_SVH
`define GERSHGORIN_EIGEN_BOUND_DEFINES_SVH

// A condition that must hold at every clock edge.
`define GEB_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GEB_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define GEB_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gebnd_pkg.sv =====
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound: package
// Field widths, limits and the payload and command types shared by the block.
// ----------------------------------------------------------------------------
package gebnd_pkg;

   localparam int H_W    = 32;
   localparam int MASS_W = 31;
   localparam int SUM_W  = 48;
   localparam int BOUND_W = 32;

   localparam int FRACTION_BITS_DEFAULT = 16;

   // Command queue between the front and back parts; depth is a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Quotient magnitude limits, one bit wider than the bound.
   localparam logic [BOUND_W:0] Q_POS_LIMIT = {2'b00, {(BOUND_W-1){1'b1}}};
   localparam logic [BOUND_W:0] Q_NEG_LIMIT = {2'b01, {(BOUND_W-1){1'b0}}};

   typedef struct packed {
      logic signed [H_W-1:0]    h_value;
      logic                     on_diagonal;
      logic        [MASS_W-1:0] mass_diag;
      logic                     row_last;
      logic                     stream_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [BOUND_W-1:0] bound_value;
      logic                      divide_fault;
   } rsp_payload_type;

   // Work handed from the front to the back: a finished row, a stream end,
   // or both at once.
   typedef struct packed {
      logic signed [SUM_W-1:0]  row_sum;
      logic        [MASS_W-1:0] mass_diag;
      logic                     row_end;
      logic                     stream_end;
   } cmd_type;

endpackage

// ===== rtl/gebnd_front.sv =====
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound: front part
// Takes entries, keeps the saturating row sum and posts row and stream ends.
// ----------------------------------------------------------------------------
module gebnd_front import gebnd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            push_valid,
   output cmd_type         push_cmd,
   input  logic            queue_full
);

   logic signed [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic signed [H_W:0]     h_ext;
   logic signed [H_W:0]     addend;
   logic signed [SUM_W:0]   wide_sum;
   logic signed [SUM_W-1:0] sum_next;
   logic                    accept;
   logic                    closes;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign closes    = req_payload.row_last || req_payload.stream_last;

   // Diagonal entries count with their sign, the others by magnitude.
   assign h_ext  = {req_payload.h_value[H_W-1], req_payload.h_value};
   assign addend = (!req_payload.on_diagonal && h_ext[H_W]) ? -h_ext : h_ext;

   assign wide_sum = {row_sum_ff[SUM_W-1], row_sum_ff}
                   + {{(SUM_W-H_W){addend[H_W]}}, addend};

   always_comb begin
      if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
         sum_next = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_next = wide_sum[SUM_W-1:0];
      end
   end

   always_comb begin
      row_sum_in = row_sum_ff;
      if (accept) begin
         row_sum_in = closes ? '0 : sum_next;
      end
   end

   assign push_valid          = accept && closes;
   assign push_cmd.row_sum    = sum_next;
   assign push_cmd.mass_diag  = req_payload.mass_diag;
   assign push_cmd.row_end    = req_payload.row_last;
   assign push_cmd.stream_end = req_payload.stream_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff <= '0;
      end else begin
         row_sum_ff <= row_sum_in;
      end
   end

endmodule

// ===== rtl/gebnd_queue.sv =====
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound: command queue
// A short first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
`include "gershgorin_eigen_bound_defines.svh"

module gebnd_queue import gebnd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `GEB_HOLDS(a_no_push_when_full, !(push_valid && full), "command pushed into a full queue")
   `GEB_HOLDS(a_count_in_range, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/gebnd_back.sv =====
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound: back part
// Divides each row sum by its nonzero mass diagonal one quotient bit per cycle,
// keeps the running maximum and the fault flag, and holds the result.
// ----------------------------------------------------------------------------
`include "gershgorin_eigen_bound_defines.svh"

module gebnd_back import gebnd_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  cmd_type         pop_cmd,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int DIV_STEPS = SUM_W + FRACTION_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]                state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic                      neg_ff, neg_in;
   logic [DIV_STEPS-1:0]      dividend_ff, dividend_in;
   logic [MASS_W-1:0]         rem_ff, rem_in;
   logic [BOUND_W:0]          quo_ff, quo_in;
   logic                      ovf_ff, ovf_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [BOUND_W-1:0] running_max_ff, running_max_in;
   logic                      max_valid_ff, max_valid_in;
   logic                      fault_ff, fault_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic [SUM_W-1:0]          pop_mag;
   logic [MASS_W:0]           trial;
   logic [MASS_W:0]           diff;
   logic                      fits;
   logic                      zero_mass;
   logic [BOUND_W:0]          limit;
   logic [BOUND_W:0]          mag_q;
   logic [BOUND_W:0]          q_full;
   logic signed [BOUND_W-1:0] q_val;
   logic                      out_free;

   assign pop_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Magnitude of the row sum; the most negative sum maps to 2^47 unsigned.
   assign pop_mag = pop_cmd.row_sum[SUM_W-1] ? (~pop_cmd.row_sum + 1'b1) : pop_cmd.row_sum;

   // One restoring division step.
   assign trial = {rem_ff, dividend_ff[DIV_STEPS-1]};
   assign diff  = trial - {1'b0, cmd_ff.mass_diag};
   assign fits  = (trial >= {1'b0, cmd_ff.mass_diag});

   // Row bound, saturated to the signed 32 bit range.
   assign zero_mass = (cmd_ff.mass_diag == '0);
   assign limit     = neg_ff ? Q_NEG_LIMIT : Q_POS_LIMIT;
   assign mag_q     = (zero_mass || ovf_ff || (quo_ff > limit)) ? limit : quo_ff;
   assign q_full    = neg_ff ? (~mag_q + 1'b1) : mag_q;
   assign q_val     = signed'(q_full[BOUND_W-1:0]);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      neg_in         = neg_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      ovf_in         = ovf_ff;
      step_in        = step_ff;
      running_max_in = running_max_ff;
      max_valid_in   = max_valid_ff;
      fault_in       = fault_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in      = pop_cmd;
               neg_in      = pop_cmd.row_sum[SUM_W-1];
               dividend_in = {pop_mag, {FRACTION_BITS{1'b0}}};
               rem_in      = '0;
               quo_in      = '0;
               ovf_in      = 1'b0;
               step_in     = '0;
               if (pop_cmd.row_end && (pop_cmd.mass_diag != '0)) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_UPD;
               end
            end
         end
         ST_DIV: begin
            rem_in      = fits ? diff[MASS_W-1:0] : trial[MASS_W-1:0];
            dividend_in = {dividend_ff[DIV_STEPS-2:0], 1'b0};
            quo_in      = {quo_ff[BOUND_W-1:0], fits};
            ovf_in      = ovf_ff || quo_ff[BOUND_W];
            step_in     = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (cmd_ff.row_end) begin
               if (!max_valid_ff || (q_val > running_max_ff)) begin
                  running_max_in = q_val;
               end
               max_valid_in = 1'b1;
               fault_in     = fault_ff || zero_mass;
            end
            state_in = cmd_ff.stream_end ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.bound_value  = running_max_ff;
               rsp_payload_in.divide_fault = fault_ff;
               running_max_in              = '0;
               max_valid_in                = 1'b0;
               fault_in                    = 1'b0;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      neg_ff         <= neg_in;
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      ovf_ff         <= ovf_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         running_max_ff <= '0;
         max_valid_ff   <= 1'b0;
         fault_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         running_max_ff <= running_max_in;
         max_valid_ff   <= max_valid_in;
         fault_ff       <= fault_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   `GEB_IMPLIES(a_rem_below_divisor, state_ff == ST_DIV, rem_ff < cmd_ff.mass_diag, "division remainder reached the divisor")
   `GEB_IMPLIES(a_step_in_range, state_ff == ST_DIV, step_ff < STEP_W'(DIV_STEPS), "division ran past its last step")
   `GEB_NEXT(a_stream_state_cleared, (state_ff == ST_OUT) && out_free, rsp_valid_ff && !max_valid_ff && !fault_ff && (running_max_ff == '0), "stream state not cleared after result load")

endmodule

// ===== rtl/gershgorin_eigen_bound.sv =====
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bound: top level
// Streams stiffness entries row by row and returns, at each stream end, the
// largest row bound (row sum over mass diagonal) and a zero-divisor flag.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    req_payload_type (one entry)
//   rsp_      out        rsp_valid/rsp_ready    rsp_payload_type (one bound)
//
// The front part takes one entry per cycle while the queue is not full and
// updates the row sum in the same cycle. Each row end or stream end posts a
// command into a four-deep queue. The back part takes a command when idle;
// a row end with a nonzero mass diagonal runs a restoring divider (one
// quotient bit per cycle) and then the update state, a row end with a zero
// mass diagonal goes straight to the update state, and a stream end then
// loads the output register once it is free. No new command is taken until
// the back part is idle again, so rows of many entries run near one transfer
// per cycle and short rows are set by the divider.
// Reset is synchronous and returns the row sum, the queue, the running
// maximum, the fault flag and the output register to empty.
// A full queue lowers req_ready; a result that is not taken holds the back
// part at stream end while the front keeps filling the queue.
//
module gershgorin_eigen_bound import gebnd_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // Front part: row accumulation with saturation at the 48 bit limits.
   gebnd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full)
   );

   // Decouples the front from the back, which takes a new command only when idle.
   gebnd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Back part: divider, running maximum and result register.
   gebnd_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_cmd     (pop_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
